// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers for the level block, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define SLE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define SLE_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SLE_ASSERT(name, clk, rst_n, prop, msg)
`define SLE_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ----- rtl/sle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// shared types and constants of the sine lfo pwm level block
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int SLE_SINE_ENTRIES = 1024;
    localparam int SLE_PHASE_GAIN   = 524288;

    localparam int POT_W   = 12;
    localparam int LEVEL_W = 16;
    localparam int PHASE_W = 32;
    localparam int SINE_W  = 16;
    localparam int AMP5_W  = 15;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    localparam logic [1:0] SLOT_OFFSET = 2'd0;
    localparam logic [1:0] SLOT_RATE   = 2'd1;
    localparam logic [1:0] SLOT_AMP    = 2'd2;

    localparam logic [LEVEL_W-1:0] PWM_MAX = 16'hffff;

    typedef struct packed {
        logic             func;
        logic [POT_W-1:0] sample_value;
        logic             mod_switch;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] pwm_level;
        logic               led_on;
    } t_out_item;

    // pot values and phase as they stand after the last accepted item
    typedef struct packed {
        logic [POT_W-1:0]   offset;
        logic [POT_W-1:0]   amp;
        logic [PHASE_W-1:0] phase;
    } t_pot_view;

endpackage

// ----- rtl/sle_state.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_state
// round robin pot store and lfo phase accumulator
// ----------------------------------------------------------------------------
module sle_state
    import sle_pkg::*;
#(
    parameter int PHASE_GAIN = SLE_PHASE_GAIN
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    output t_pot_view o_view
);

    logic [POT_W-1:0]   r_pot [3];
    logic [POT_W-1:0]   n_pot [3];
    logic [1:0]         r_slot, n_slot;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [1:0]         w_slot;
    logic [PHASE_W-1:0] w_step;

    // unused slot code behaves as the offset slot
    assign w_slot = (r_slot == 2'd3) ? SLOT_OFFSET : r_slot;
    assign w_step = PHASE_W'(PHASE_W'(r_pot[SLOT_RATE]) * PHASE_W'(PHASE_GAIN));

    always_comb begin
        n_pot   = r_pot;
        n_slot  = r_slot;
        n_phase = r_phase;
        if (i_accept) begin
            if (i_item.func == FUNC_SAMPLE) begin
                n_pot[w_slot] = i_item.sample_value;
                n_slot = (w_slot >= SLOT_AMP) ? SLOT_OFFSET : w_slot + 2'd1;
            end else begin
                n_phase = r_phase + w_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pot   <= '{default: '0};
            r_slot  <= SLOT_OFFSET;
            r_phase <= '0;
        end else begin
            r_pot   <= n_pot;
            r_slot  <= n_slot;
            r_phase <= n_phase;
        end
    end

    assign o_view.offset = r_pot[SLOT_OFFSET];
    assign o_view.amp    = r_pot[SLOT_AMP];
    assign o_view.phase  = r_phase;

endmodule

// ----- rtl/sle_sine_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_sine_rom
// q1.15 sine table built at elaboration, registered read
// ----------------------------------------------------------------------------
module sle_sine_rom
    import sle_pkg::*;
#(
    parameter int SINE_ENTRIES = SLE_SINE_ENTRIES
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [PHASE_W-1:0]       i_phase,
    output logic signed [SINE_W-1:0] o_sine
);

    localparam int IDX_W = $clog2(SINE_ENTRIES);
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned ENTRIES_U   = 64'(SINE_ENTRIES);

    typedef logic [SINE_ENTRIES-1:0][SINE_W-1:0] t_rom;

    // two truncated q2.30 products: term * x * x
    function automatic longint unsigned next_term(input longint unsigned t,
                                                  input longint unsigned x);
        longint unsigned p;
        p = (t * x) >> 30;
        return (p * x) >> 30;
    endfunction

    // sin(pi/2 * u / entries), taylor series to the x^15 term
    function automatic logic [SINE_W-1:0] quarter_sine(input longint unsigned u);
        longint unsigned x;
        longint unsigned term;
        longint unsigned r;
        longint          sum;
        x    = (PI_HALF_Q30 * u) / ENTRIES_U;
        term = x;
        sum  = longint'(x);
        term = next_term(term, x) / 6;   sum = sum - longint'(term);
        term = next_term(term, x) / 20;  sum = sum + longint'(term);
        term = next_term(term, x) / 42;  sum = sum - longint'(term);
        term = next_term(term, x) / 72;  sum = sum + longint'(term);
        term = next_term(term, x) / 110; sum = sum - longint'(term);
        term = next_term(term, x) / 156; sum = sum + longint'(term);
        term = next_term(term, x) / 210; sum = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
        end
        r = ((unsigned'(sum) * 64'd32767) + 64'd536870912) >> 30;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return SINE_W'(r);
    endfunction

    function automatic t_rom build_table();
        t_rom              tab;
        longint unsigned   q;
        longint unsigned   quad;
        longint unsigned   rem;
        longint unsigned   u;
        logic [SINE_W-1:0] v;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            q    = 64'(4 * i);
            quad = q / ENTRIES_U;
            rem  = q % ENTRIES_U;
            u    = quad[0] ? (ENTRIES_U - rem) : rem;
            v    = quarter_sine(u);
            tab[i] = (quad >= 64'd2) ? SINE_W'(-v) : v;
        end
        return tab;
    endfunction

    localparam t_rom SINE_ROM = build_table();

    logic [PHASE_W+IDX_W:0] w_scaled;
    logic [IDX_W-1:0]       w_addr;
    logic [SINE_W-1:0]      r_sine;

    // index = floor(phase * entries / 2^32)
    assign w_scaled = {{(IDX_W+1){1'b0}}, i_phase} * (PHASE_W+IDX_W+1)'(SINE_ENTRIES);
    assign w_addr   = w_scaled[PHASE_W +: IDX_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sine <= SINE_ROM[w_addr];
        end
    end

    assign o_sine = signed'(r_sine);

endmodule

// ----- rtl/sle_mix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_mix
// base level with optional sine modulation and saturation
// ----------------------------------------------------------------------------
module sle_mix
    import sle_pkg::*;
(
    input  logic [LEVEL_W-1:0]       i_base,
    input  logic [AMP5_W-1:0]        i_amp5,
    input  logic signed [SINE_W-1:0] i_sine,
    input  logic                     i_mod,
    output logic [LEVEL_W-1:0]       o_level
);

    logic signed [31:0]        w_prod;
    logic signed [16:0]        w_delta;
    logic signed [LEVEL_W+1:0] w_sum;

    assign w_prod  = signed'({1'b0, i_amp5}) * i_sine;
    // arithmetic shift gives floor for both signs
    assign w_delta = w_prod[31:15];
    assign w_sum   = signed'({2'b00, i_base}) + (LEVEL_W+2)'(w_delta);

    always_comb begin
        if (!i_mod) begin
            o_level = i_base;
        end else if (w_sum < 0) begin
            o_level = '0;
        end else if (w_sum > signed'({2'b00, PWM_MAX})) begin
            o_level = PWM_MAX;
        end else begin
            o_level = w_sum[LEVEL_W-1:0];
        end
    end

endmodule

// ----- rtl/sine_lfo_pwm_level.sv -----
`timescale 1ns / 1ps
// a result is offered from the result register once its item has passed stage 1 and stage 2
// throughput: one item per cycle while results are taken; three register stages (state, table, result)
// the sine table read is one registered rom port, the level a single multiply
// reset (synchronous, active low) clears pot slots, slot pointer, phase, valids
// ready falls only when every stage holds an item and the result is not taken
// ----------------------------------------------------------------------------
// sine_lfo_pwm_level
// pwm level from an offset pot with optional sine lfo modulation
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sine_lfo_pwm_level
    import sle_pkg::*;
#(
    parameter int SINE_ENTRIES = SLE_SINE_ENTRIES,
    parameter int PHASE_GAIN   = SLE_PHASE_GAIN
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // handshake between stages
    logic w_in_accept;
    logic w_out_free;
    logic w_s2_free;
    logic w_s1_free;

    // stage 1: item whose state update has landed
    logic r_s1_valid;
    logic r_s1_mod;

    // stage 2: base level, scaled amplitude, sine from the rom
    logic                     r_s2_valid;
    logic                     r_s2_mod;
    logic [LEVEL_W-1:0]       r_s2_base;
    logic [AMP5_W-1:0]        r_s2_amp5;
    logic signed [SINE_W-1:0] w_sine;

    // result register
    logic      r_out_valid;
    t_out_item r_out_item;

    t_pot_view          w_view;
    logic [27:0]        w_base_wide;
    logic [LEVEL_W-1:0] w_base;
    logic [AMP5_W-1:0]  w_amp5;
    logic [LEVEL_W-1:0] w_level;

    // a stage takes a new item when empty or when it hands its own on
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_s2_free   = !r_s2_valid || w_out_free;
    assign w_s1_free   = !r_s1_valid || w_s2_free;
    assign o_in_ready  = w_s1_free;
    assign w_in_accept = i_in_valid && o_in_ready;

    // pot store and phase update at the accept edge
    sle_state #(
        .PHASE_GAIN(PHASE_GAIN)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_in_accept),
        .i_item  (i_in_item),
        .o_view  (w_view)
    );

    // state stays put while stage 1 waits, since no item can enter then
    // base = floor(offset * 65535 / 4096)
    assign w_base_wide = {w_view.offset, 16'h0000} - 28'(w_view.offset);
    assign w_base      = w_base_wide[27:12];
    // 5 * amplitude as shift and add
    assign w_amp5      = {w_view.amp, 2'b00} + AMP5_W'(w_view.amp);

    // table read moves with stage 2
    sle_sine_rom #(
        .SINE_ENTRIES(SINE_ENTRIES)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (w_s2_free),
        .i_phase(w_view.phase),
        .o_sine (w_sine)
    );

    sle_mix u_mix (
        .i_base (r_s2_base),
        .i_amp5 (r_s2_amp5),
        .i_sine (w_sine),
        .i_mod  (r_s2_mod),
        .o_level(w_level)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= w_in_accept;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_s1_free) begin
            r_s1_mod <= i_in_item.mod_switch;
        end
        if (w_s2_free) begin
            r_s2_mod  <= r_s1_mod;
            r_s2_base <= w_base;
            r_s2_amp5 <= w_amp5;
        end
        if (w_out_free) begin
            r_out_item.pwm_level <= w_level;
            r_out_item.led_on    <= r_s2_mod;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // an accepted item always reaches stage 1
    `SLE_ASSERT(a_accept_fills_s1, i_clk, i_rst_n, w_in_accept |=> r_s1_valid, "item lost at stage 1")
    // a held stage 1 item is not dropped
    `SLE_ASSERT(a_s1_holds, i_clk, i_rst_n, (r_s1_valid && !w_s2_free) |=> r_s1_valid, "stage 1 item dropped")
    // stage 2 item moves into the result register when it is free
    `SLE_ASSERT(a_s2_to_out, i_clk, i_rst_n, (r_s2_valid && w_out_free) |=> r_out_valid, "stage 2 item lost")
    // reset empties the pipeline
    `SLE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_s1_valid && !r_s2_valid && !o_out_valid), "pipeline not empty after reset")

endmodule
